FILE: rtl/pal_pkg.sv
`default_nettype none

package pal_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = 6;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_CNT_W = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_REM_FRONT = 3'd3,
        ACT_REM_BACK  = 3'd4,
        ACT_REM_AT    = 3'd5,
        ACT_READ_AT   = 3'd6,
        ACT_NOP       = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } op_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] target;
        logic             take_data;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/pal_cell.sv
`default_nettype none

module pal_cell
    import pal_pkg::*;
(
    input  wire logic                  clk,
    input  wire cmd_t                  cmd,
    input  wire logic [IDX_W-1:0]      idx,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0]      data,
    output logic [DATA_WIDTH-1:0]      hit_data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (idx > cmd.target)
                begin
                    data_next = left_data;
                end
                else if (idx == cmd.target)
                begin
                    data_next = value;
                end
            end
            OP_DEL:
            begin
                if (idx >= cmd.target)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // only the addressed cell drives the read bus
    assign hit_data = (idx == cmd.target) ? data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/pal_ctrl.sv
`default_nettype none

module pal_ctrl
    import pal_pkg::*;
(
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic [CNT_W-1:0]    count,
    output cmd_t                     cmd,
    output status_t                  status,
    output logic [CNT_W-1:0]         count_next
);

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             full;
    logic             empty;

    assign pos_c = CMP_W'(position);
    assign cnt_c = CMP_W'(count);
    assign full  = (count >= CNT_W'(CAPACITY));
    assign empty = (count == '0);

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.target    = '0;
        cmd.take_data = 1'b0;
        status        = ST_OK;
        count_next    = count;
        case (action_t'(action))
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (action_t'(action) == ACT_INS_AT && pos_c > cnt_c)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    cmd.op     = OP_INS;
                    count_next = count + CNT_W'(1);
                    if (action_t'(action) == ACT_INS_BACK)
                    begin
                        cmd.target = IDX_W'(count);
                    end
                    else if (action_t'(action) == ACT_INS_AT)
                    begin
                        cmd.target = IDX_W'(position);
                    end
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT, ACT_READ_AT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if ((action_t'(action) == ACT_REM_AT
                          || action_t'(action) == ACT_READ_AT) && pos_c >= cnt_c)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    cmd.take_data = 1'b1;
                    if (action_t'(action) == ACT_REM_BACK)
                    begin
                        cmd.target = IDX_W'(count - CNT_W'(1));
                    end
                    else if (action_t'(action) != ACT_REM_FRONT)
                    begin
                        cmd.target = IDX_W'(position);
                    end
                    if (action_t'(action) != ACT_READ_AT)
                    begin
                        cmd.op     = OP_DEL;
                        count_next = count - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/positional_array_list.sv
`default_nettype none

// Bounded ordered list of up to CAPACITY words with insert and remove at the
// front, the back or a given position, and read at a given position. Each
// list entry lives in its own cell of a row; an insert or remove moves every
// affected entry one place to its neighbor at once, so one request is taken
// every clock unless the reply is stalled, and its result word appears on the
// master side in the cycle after acceptance. Errors (full, empty, bad position)
// leave the list untouched.

module positional_array_list
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // action[2:0], position[8:3], value[40:9]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // status[1:0], data_out[33:2], count_out[39:34]
);

    logic [ACTION_W-1:0]   action;
    logic [POS_W-1:0]      position;
    logic [DATA_WIDTH-1:0] value;
    logic                  accept;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cmd_t             dec_cmd;
    cmd_t             cell_cmd;
    status_t          dec_status;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_hit  [CAPACITY];
    logic [DATA_WIDTH-1:0] read_data;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_CNT_W-1:0]  out_count_reg;

    assign action   = s_tdata[2:0];
    assign position = s_tdata[8:3];
    assign value    = DATA_WIDTH'(s_tdata[40:9]);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    pal_ctrl u_ctrl (
        .action     (action),
        .position   (position),
        .count      (count_reg),
        .cmd        (dec_cmd),
        .status     (dec_status),
        .count_next (count_next)
    );

    // cells only move on an accepted word
    always_comb
    begin
        cell_cmd = dec_cmd;
        if (!accept)
        begin
            cell_cmd.op = OP_NONE;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        pal_cell u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .idx        (IDX_W'(i)),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_data = read_data | cell_hit[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= dec_status;
            out_data_reg   <= dec_cmd.take_data ? OUT_DATA_W'(read_data) : '0;
            out_count_reg  <= OUT_CNT_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_data_reg, out_status_reg};

endmodule

`default_nettype wire

FILE: tb/list_reply_checker.sv
`default_nettype none

module list_reply_checker
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,  // action[2:0], position[8:3], value[40:9]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,  // status[1:0], data_out[33:2], count_out[39:34]
    output int               mismatches,
    output int               awaiting
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t               status;
        logic [OUT_DATA_W-1:0] data;
        logic [OUT_CNT_W-1:0]  count;
    } reply_t;

    logic [DATA_WIDTH-1:0] cells [CAPACITY+1];
    int                    fill;
    reply_t                expected_replies[$];
    reply_t                oldest;
    int                    fail_tally = 0;

    assign mismatches = fail_tally;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        fail_tally++;
    endtask

    // mirror of the list: apply one request and queue the reply it should give
    task automatic predict_reply(input action_t act, input logic [5:0] pos,
                                 input logic [31:0] val);
        reply_t r;
        int     at;
        int     i;
        r.status = ST_OK;
        r.data   = '0;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else if (act == ACT_INS_AT && pos > fill)
                    r.status = ST_BADPOS;
                else
                begin
                    at = (act == ACT_INS_FRONT) ? 0 : (act == ACT_INS_BACK) ? fill : int'(pos);
                    for (i = fill; i > at; i--)
                        cells[i] = cells[i-1];
                    cells[at] = val[DATA_WIDTH-1:0];
                    fill++;
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT, ACT_READ_AT:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if ((act == ACT_REM_AT || act == ACT_READ_AT) && pos >= fill)
                    r.status = ST_BADPOS;
                else
                begin
                    at = (act == ACT_REM_FRONT) ? 0 : (act == ACT_REM_BACK) ? fill - 1 : int'(pos);
                    r.data = OUT_DATA_W'(cells[at]);
                    if (act != ACT_READ_AT)
                    begin
                        fill--;
                        for (i = at; i < fill; i++)
                            cells[i] = cells[i+1];
                    end
                end
            end
            default:
                ;
        endcase
        r.count = OUT_CNT_W'(fill);
        expected_replies.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_replies.delete();
            fill = 0;
            awaiting <= 0;
        end
        else
        begin
            // reply side first: a word accepted now belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                    report("reply word with nothing pending", 64'(m_tdata), '0);
                else
                begin
                    oldest = expected_replies.pop_front();
                    if (m_tdata[1:0] !== oldest.status)
                        report("status", 64'(m_tdata[1:0]), 64'(oldest.status));
                    if (m_tdata[33:2] !== oldest.data)
                        report("data_out", 64'(m_tdata[33:2]), 64'(oldest.data));
                    if (m_tdata[39:34] !== oldest.count)
                        report("count_out", 64'(m_tdata[39:34]), 64'(oldest.count));
                end
            end
            if (s_tvalid && s_tready)
                predict_reply(action_t'(s_tdata[2:0]), s_tdata[8:3], s_tdata[40:9]);
            awaiting <= expected_replies.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/positional_array_list_test.sv
`default_nettype none

module positional_array_list_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int PHASE_ITEMS    = 225;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int fails;
    int pending;
    bit filling      = 1'b0;

    positional_array_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_reply_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (fails),
        .awaiting   (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [47:0] pack_request(input action_t act, input logic [5:0] pos,
                                                 input logic [31:0] val);
        return {7'b0, val, pos, act};
    endfunction

    // insert-heavy while filling, remove/read-heavy while draining
    function automatic logic [47:0] random_request(input bit grow);
        int       roll;
        action_t  act;
        logic [5:0] pos;
        roll = $urandom_range(99);
        if (roll < 3)
            act = ACT_NOP;
        else if (roll < (grow ? 80 : 20))
            act = action_t'($urandom_range(2));
        else
            act = action_t'($urandom_range(6, 3));
        pos = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(CAPACITY));
        return pack_request(act, pos, $urandom());
    endfunction

    task automatic send_request(input logic [47:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin
        int phase;
        int sent;
        int burst;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, extremes of value and position
        send_request(pack_request(ACT_REM_FRONT, 6'd0,  32'h0));
        send_request(pack_request(ACT_REM_BACK,  6'd0,  32'h0));
        send_request(pack_request(ACT_REM_AT,    6'd0,  32'h0));
        send_request(pack_request(ACT_READ_AT,   6'd0,  32'h0));
        send_request(pack_request(ACT_INS_AT,    6'd1,  32'h1234_5678));
        send_request(pack_request(ACT_NOP,       6'd63, 32'hFFFF_FFFF));
        send_request(pack_request(ACT_INS_FRONT, 6'd63, 32'hFFFF_FFFF));
        send_request(pack_request(ACT_INS_BACK,  6'd0,  32'h0000_0000));
        send_request(pack_request(ACT_INS_AT,    6'd2,  32'hA5A5_A5A5));
        send_request(pack_request(ACT_INS_AT,    6'd1,  32'h5A5A_5A5A));
        send_request(pack_request(ACT_INS_AT,    6'd63, 32'h0000_0001));
        send_request(pack_request(ACT_INS_AT,    6'd0,  32'h8000_0000));
        send_request(pack_request(ACT_READ_AT,   6'd0,  32'h0));
        send_request(pack_request(ACT_READ_AT,   6'd4,  32'h0));
        send_request(pack_request(ACT_READ_AT,   6'd5,  32'h0));
        send_request(pack_request(ACT_READ_AT,   6'd63, 32'h0));
        send_request(pack_request(ACT_REM_AT,    6'd63, 32'h0));
        send_request(pack_request(ACT_REM_AT,    6'd5,  32'h0));
        send_request(pack_request(ACT_REM_AT,    6'd1,  32'h0));
        send_request(pack_request(ACT_REM_BACK,  6'd0,  32'h0));
        send_request(pack_request(ACT_NOP,       6'd0,  32'h0));
        send_request(pack_request(ACT_REM_FRONT, 6'd0,  32'h0));
        send_request(pack_request(ACT_REM_FRONT, 6'd0,  32'h0));
        send_request(pack_request(ACT_REM_FRONT, 6'd0,  32'h0));
        send_request(pack_request(ACT_READ_AT,   6'd0,  32'h0));

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                filling = ~filling;
                burst = $urandom_range(90, 30);
                repeat (burst)
                begin
                    if (sent < PHASE_ITEMS)
                    begin
                        send_request(random_request(filling));
                        sent++;
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);

        if (fails == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_ctrl.sv
rtl/positional_array_list.sv
tb/list_reply_checker.sv
tb/positional_array_list_test.sv
